// ===== hdl/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle step package
// kind codes, colour ramps and small arithmetic helpers
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam logic [3:0] KIND_STATIC     = 4'd0;
    localparam logic [3:0] KIND_GRAV       = 4'd1;
    localparam logic [3:0] KIND_SLOWGRAV   = 4'd2;
    localparam logic [3:0] KIND_FIRE       = 4'd3;
    localparam logic [3:0] KIND_EXPLODE    = 4'd4;
    localparam logic [3:0] KIND_EXPLODE2   = 4'd5;
    localparam logic [3:0] KIND_BLOB       = 4'd6;
    localparam logic [3:0] KIND_BLOB2      = 4'd7;
    localparam logic [3:0] KIND_SMOKE      = 4'd8;
    localparam logic [3:0] KIND_SMOKECLOUD = 4'd9;
    localparam logic [3:0] KIND_BLOODCLOUD = 4'd10;
    localparam logic [3:0] KIND_FADESPARK  = 4'd11;
    localparam logic [3:0] KIND_FADESPARK2 = 4'd12;
    localparam logic [3:0] KIND_FALLFADE   = 4'd13;
    localparam logic [3:0] KIND_FALLSPARK  = 4'd14;
    localparam logic [3:0] KIND_FLAME      = 4'd15;

    localparam logic CFG_FRAME_TIME = 1'b0;
    localparam logic CFG_GRAVITY    = 1'b1;

    localparam logic [15:0] FRAME_TIME_RST = 16'd1092;
    localparam logic [11:0] GRAVITY_RST    = 12'd800;

    // velocity growth modes
    typedef enum logic [1:0] {GROW_NONE, GROW_K4, GROW_K1, GROW_KNEG4} grow_t;

    function automatic logic [7:0] ramp_a(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = 8'h6f;
            3'd1: r = 8'h6d;
            3'd2: r = 8'h6b;
            3'd3: r = 8'h69;
            3'd4: r = 8'h67;
            3'd5: r = 8'h65;
            3'd6: r = 8'h63;
            default: r = 8'h61;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ramp_b(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = 8'h6f;
            3'd1: r = 8'h6e;
            3'd2: r = 8'h6d;
            3'd3: r = 8'h6c;
            3'd4: r = 8'h6b;
            3'd5: r = 8'h6a;
            3'd6: r = 8'h68;
            default: r = 8'h66;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ramp_c(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = 8'h6d;
            3'd1: r = 8'h6b;
            3'd2: r = 8'h06;
            3'd3: r = 8'h05;
            3'd4: r = 8'h04;
            3'd5: r = 8'h03;
            3'd6: r = 8'h02;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

    // floor(x / 5) for a 16-bit value by reciprocal multiply
    function automatic logic [15:0] div5_16(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd52429;
        return {2'b00, p[31:18]};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
        logic signed [31:0] r;
        if (x > 51'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -51'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
        logic signed [15:0] r;
        if (x > 18'sd32767)
            r = 16'sh7fff;
        else if (x < -18'sd32768)
            r = 16'sh8000;
        else
            r = x[15:0];
        return r;
    endfunction

endpackage

// ===== hdl/particle_physics_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle physics step
// advances one particle by one frame in a three-stage pipeline
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid / in_stall carries one particle per beat; the
//   output channel out_valid / out_stall returns the updated particle
//   a beat moves when valid is high and stall is low
//   frame_time (index 0) and gravity_accel (index 1) are written through
//   cfg_we / cfg_index / cfg_data while the pipeline is empty
// timing
//   an input beat passes the stage 1, stage 2 and output registers to out_valid
//   one particle per cycle sustained while the output is not stalled; the
//   multipliers of stages 1 and 2 (velocity products, gravity reciprocal, fire alpha) set the stage depth
// stall
//   the whole pipeline freezes while the output register holds a beat that
//   the receiver stalls; in_stall follows, nothing is dropped or repeated
// reset
//   rst_n clears all stage valid bits and loads the config defaults
//   (frame time 1092, gravity 800)
// ----------------------------------------------------------------------------
module particle_physics_step
    import pps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic        [15:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic         [3:0] kind,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic        [15:0] ramp_in,
    input  logic signed [15:0] alpha_in,
    input  logic signed [15:0] scale_in,
    input  logic         [7:0] color_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic        [15:0] ramp_out,
    output logic signed [15:0] alpha_out,
    output logic signed [15:0] scale_out,
    output logic         [7:0] color_out,
    output logic               dead
);

    // config
    logic [15:0] ft_reg;
    logic [11:0] ga_reg;

    logic adv;

    // input arrays
    logic signed [31:0] pin [3];
    logic signed [31:0] vin [3];

    // stage 1
    logic               s1_valid_reg;
    logic         [3:0] s1_kind_reg;
    logic signed [31:0] s1_pos_reg [3];
    logic signed [31:0] s1_vel_reg [3];
    logic signed [48:0] s1_prod_reg [3];
    logic signed [48:0] s1_prod_next [3];
    logic        [27:0] s1_gfull_reg;
    logic        [15:0] s1_ramp_reg;
    logic        [15:0] s1_ramp_next;
    logic               s1_rdead_reg;
    logic               s1_rdead_next;
    logic               s1_isalpha_reg;
    logic               s1_isalpha_next;
    logic        [15:0] s1_adelta_reg;
    logic        [15:0] s1_adelta_next;
    logic signed [15:0] s1_alpha_reg;
    logic signed [15:0] s1_scale_in_reg;
    logic signed [15:0] s1_scale_reg;
    logic signed [15:0] s1_scale_next;
    logic         [7:0] s1_color_reg;

    // stage 1 comb helpers
    logic  [3:0] rate;
    logic [19:0] rmul;
    logic [16:0] rsum;
    logic [15:0] rlimit;
    logic [19:0] ft11;
    logic [20:0] ft25;
    logic signed [15:0] sdelta;

    // stage 2
    logic               s2_valid_reg;
    logic         [3:0] s2_kind_reg;
    logic signed [31:0] s2_pos_in_reg [3];
    logic signed [31:0] s2_vel_in_reg [3];
    logic signed [31:0] s2_pos_reg [3];
    logic signed [31:0] s2_pos_next [3];
    logic signed [31:0] s2_vel_reg [3];
    logic signed [31:0] s2_vel_next [3];
    logic        [27:0] s2_gfull_reg;
    logic        [23:0] s2_gnorm_reg;
    logic        [23:0] s2_gnorm_next;
    logic        [23:0] s2_gslow_reg;
    logic        [23:0] s2_gslow_next;
    logic        [15:0] s2_ramp_reg;
    logic               s2_rdead_reg;
    logic               s2_dead_reg;
    logic               s2_dead_next;
    logic               s2_aact_reg;
    logic               s2_aact_next;
    logic signed [15:0] s2_alpha_in_reg;
    logic signed [15:0] s2_alpha_reg;
    logic signed [15:0] s2_alpha_next;
    logic        [14:0] s2_fa_reg;
    logic        [14:0] s2_fa_next;
    logic signed [15:0] s2_scale_in_reg;
    logic signed [15:0] s2_scale_reg;
    logic         [7:0] s2_color_in_reg;
    logic         [7:0] s2_color_reg;
    logic         [7:0] s2_color_next;

    // stage 2 comb helpers
    grow_t              gmode;
    logic signed [17:0] adiff;
    logic        [15:0] fx;
    logic        [15:0] fy;
    logic        [31:0] fprod;
    logic        [57:0] gn_prod;
    logic        [29:0] g3;
    logic        [57:0] gs_prod;
    logic signed [49:0] term [3];

    // output stage
    logic               out_valid_reg;
    logic signed [31:0] out_pos_reg [3];
    logic signed [31:0] out_pos_next [3];
    logic signed [31:0] out_vel_reg [3];
    logic signed [31:0] out_vel_next [3];
    logic        [15:0] out_ramp_reg;
    logic signed [15:0] out_alpha_reg;
    logic signed [15:0] out_alpha_next;
    logic signed [15:0] out_scale_reg;
    logic signed [15:0] out_scale_next;
    logic         [7:0] out_color_reg;
    logic         [7:0] out_color_next;
    logic               out_dead_reg;
    logic signed [28:0] grav;
    logic signed [31:0] vz;

    // pipeline moves unless a finished beat is stalled at the output
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ft_reg <= FRAME_TIME_RST;
            ga_reg <= GRAVITY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_TIME: ft_reg <= cfg_data;
                CFG_GRAVITY:    ga_reg <= cfg_data[11:0];
                default:        ft_reg <= ft_reg;
            endcase
        end
    end

    assign pin[0] = pos_x;
    assign pin[1] = pos_y;
    assign pin[2] = pos_z;
    assign vin[0] = vel_x;
    assign vin[1] = vel_y;
    assign vin[2] = vel_z;

    // ---------------- stage 1: products, ramp step, alpha and scale deltas
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s1_prod_next[i] = $signed({1'b0, ft_reg}) * vin[i];

        case (kind)
            KIND_FIRE:                    rate = 4'd5;
            KIND_EXPLODE:                 rate = 4'd10;
            KIND_EXPLODE2, KIND_FALLSPARK: rate = 4'd15;
            default:                      rate = 4'd0;
        endcase
        rmul = 20'(ft_reg) * 20'(rate);
        rsum = 17'(ramp_in) + 17'(rmul[19:8]);
        s1_ramp_next = rsum[16] ? 16'hffff : rsum[15:0];
        rlimit = (kind == KIND_FIRE) ? 16'd1536 : 16'd2048;
        s1_rdead_next = (rate != 4'd0) && (s1_ramp_next >= rlimit);

        ft11 = 20'(ft_reg) * 20'd11;
        ft25 = 21'(ft_reg) * 21'd25;
        s1_isalpha_next = 1'b1;
        sdelta = 16'sd0;
        case (kind)
            KIND_SMOKE:
            begin
                s1_adelta_next = div5_16({1'b0, ft_reg[15:1]});
                sdelta = $signed({6'b0, ft_reg[15:6]});
            end
            KIND_SMOKECLOUD:
            begin
                s1_adelta_next = div5_16(ft11[19:4]);
                sdelta = $signed({2'b0, ft25[20:7]});
            end
            KIND_BLOODCLOUD:
            begin
                s1_adelta_next = {4'b0, ft_reg[15:4]};
                sdelta = $signed({6'b0, ft_reg[15:6]});
            end
            KIND_FALLFADE, KIND_FALLSPARK:
                s1_adelta_next = {2'b0, ft_reg[15:2]};
            KIND_FLAME:
            begin
                s1_adelta_next = {5'b0, ft_reg[15:5]};
                sdelta = -$signed({7'b0, ft_reg[15:7]});
            end
            default:
            begin
                s1_adelta_next = 16'd0;
                s1_isalpha_next = 1'b0;
            end
        endcase
        s1_scale_next = sat16(18'(scale_in) + 18'(sdelta));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg     <= kind;
            for (int i = 0; i < 3; i++)
            begin
                s1_pos_reg[i]  <= pin[i];
                s1_vel_reg[i]  <= vin[i];
                s1_prod_reg[i] <= s1_prod_next[i];
            end
            s1_gfull_reg    <= 28'(ft_reg) * 28'(ga_reg);
            s1_ramp_reg     <= s1_ramp_next;
            s1_rdead_reg    <= s1_rdead_next;
            s1_isalpha_reg  <= s1_isalpha_next;
            s1_adelta_reg   <= s1_adelta_next;
            s1_alpha_reg    <= alpha_in;
            s1_scale_in_reg <= scale_in;
            s1_scale_reg    <= s1_scale_next;
            s1_color_reg    <= color_in;
        end
    end

    // ---------------- stage 2: alpha, fire alpha, gravity split, growth, position
    always_comb
    begin
        adiff = 18'(s1_alpha_reg) - $signed({2'b0, s1_adelta_reg});
        s2_alpha_next = sat16(adiff);
        // the falling spark only fades while its ramp is still alive
        s2_aact_next = s1_isalpha_reg && !s1_rdead_reg;
        s2_dead_next = s1_rdead_reg || (s2_aact_next && (s2_alpha_next <= 16'sd0));

        // fire alpha = (1536 - ramp) * 32 / 3
        fx = 16'd1536 - s1_ramp_reg;
        fy = {fx[10:0], 5'b0};
        fprod = 32'(fy) * 32'd43691;
        s2_fa_next = fprod[31:17];

        // gravity at 1/20 and 3/80 of full strength
        gn_prod = 58'(s1_gfull_reg[27:2]) * 58'h0cccccccd;
        s2_gnorm_next = gn_prod[57:34];
        g3 = 30'(s1_gfull_reg) * 30'd3;
        gs_prod = 58'(g3[29:4]) * 58'h0cccccccd;
        s2_gslow_next = gs_prod[57:34];

        case (s1_kind_reg)
            KIND_EXPLODE, KIND_BLOB: gmode = GROW_K4;
            KIND_EXPLODE2:           gmode = GROW_K1;
            KIND_BLOB2:              gmode = GROW_KNEG4;
            default:                 gmode = GROW_NONE;
        endcase

        for (int i = 0; i < 3; i++)
        begin
            case (gmode)
                GROW_K4:    term[i] = 50'(s1_prod_reg[i]) >>> 14;
                GROW_K1:    term[i] = 50'(s1_prod_reg[i]) >>> 16;
                GROW_KNEG4:
                    if (i < 2)
                        term[i] = -((50'(s1_prod_reg[i]) + 50'sd16383) >>> 14);
                    else
                        term[i] = 50'sd0;
                default:    term[i] = 50'sd0;
            endcase
            s2_vel_next[i] = sat32(51'(s1_vel_reg[i]) + 51'(term[i]));
            s2_pos_next[i] = sat32(51'(s1_pos_reg[i]) + 51'(s1_prod_reg[i] >>> 16));
        end

        case (s1_kind_reg)
            KIND_FIRE:                    s2_color_next = ramp_c(s1_ramp_reg[10:8]);
            KIND_EXPLODE, KIND_FALLSPARK: s2_color_next = ramp_a(s1_ramp_reg[10:8]);
            KIND_EXPLODE2:                s2_color_next = ramp_b(s1_ramp_reg[10:8]);
            default:                      s2_color_next = s1_color_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= s1_kind_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_pos_in_reg[i] <= s1_pos_reg[i];
                s2_vel_in_reg[i] <= s1_vel_reg[i];
                s2_pos_reg[i]    <= s2_pos_next[i];
                s2_vel_reg[i]    <= s2_vel_next[i];
            end
            s2_gfull_reg    <= s1_gfull_reg;
            s2_gnorm_reg    <= s2_gnorm_next;
            s2_gslow_reg    <= s2_gslow_next;
            s2_ramp_reg     <= s1_ramp_reg;
            s2_rdead_reg    <= s1_rdead_reg;
            s2_dead_reg     <= s2_dead_next;
            s2_aact_reg     <= s2_aact_next;
            s2_alpha_in_reg <= s1_alpha_reg;
            s2_alpha_reg    <= s2_alpha_next;
            s2_fa_reg       <= s2_fa_next;
            s2_scale_in_reg <= s1_scale_in_reg;
            s2_scale_reg    <= s1_scale_reg;
            s2_color_in_reg <= s1_color_reg;
            s2_color_reg    <= s2_color_next;
        end
    end

    // ---------------- stage 3: gravity on vel_z, dead pass-through
    always_comb
    begin
        case (s2_kind_reg)
            KIND_FIRE:
                grav = $signed({5'b0, s2_gnorm_reg});
            KIND_GRAV, KIND_SLOWGRAV, KIND_EXPLODE, KIND_EXPLODE2, KIND_BLOB,
            KIND_BLOB2, KIND_BLOODCLOUD:
                grav = -$signed({5'b0, s2_gnorm_reg});
            KIND_SMOKECLOUD:
                grav = $signed({5'b0, s2_gslow_reg});
            KIND_FALLFADE, KIND_FALLSPARK:
                grav = -$signed({1'b0, s2_gfull_reg});
            default:
                grav = 29'sd0;
        endcase
        vz = sat32(51'(s2_vel_reg[2]) + 51'(grav));

        for (int i = 0; i < 3; i++)
        begin
            out_pos_next[i] = s2_dead_reg ? s2_pos_in_reg[i] : s2_pos_reg[i];
            out_vel_next[i] = s2_dead_reg ? s2_vel_in_reg[i]
                            : ((i == 2) ? vz : s2_vel_reg[i]);
        end

        if (s2_kind_reg == KIND_FIRE)
            out_alpha_next = s2_rdead_reg ? s2_alpha_in_reg : $signed({1'b0, s2_fa_reg});
        else if (s2_aact_reg)
            out_alpha_next = s2_alpha_reg;
        else
            out_alpha_next = s2_alpha_in_reg;

        out_scale_next = s2_dead_reg ? s2_scale_in_reg : s2_scale_reg;
        out_color_next = s2_dead_reg ? s2_color_in_reg : s2_color_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_pos_reg[i] <= out_pos_next[i];
                out_vel_reg[i] <= out_vel_next[i];
            end
            out_ramp_reg  <= s2_ramp_reg;
            out_alpha_reg <= out_alpha_next;
            out_scale_reg <= out_scale_next;
            out_color_reg <= out_color_next;
            out_dead_reg  <= s2_dead_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_pos_x = out_pos_reg[0];
    assign new_pos_y = out_pos_reg[1];
    assign new_pos_z = out_pos_reg[2];
    assign new_vel_x = out_vel_reg[0];
    assign new_vel_y = out_vel_reg[1];
    assign new_vel_z = out_vel_reg[2];
    assign ramp_out  = out_ramp_reg;
    assign alpha_out = out_alpha_reg;
    assign scale_out = out_scale_reg;
    assign color_out = out_color_reg;
    assign dead      = out_dead_reg;

    // kinds without ramp or fade never die
    a_static_alive: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && (s2_kind_reg == KIND_STATIC || s2_kind_reg == KIND_GRAV ||
                         s2_kind_reg == KIND_BLOB || s2_kind_reg == KIND_BLOB2)
        |-> !s2_dead_reg)
        else $error("particle without limits marked dead");

    // a live fire particle has alpha in (0, 1.0]
    a_fire_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && adv && s2_kind_reg == KIND_FIRE && !s2_dead_reg
        |=> out_alpha_reg > 16'sd0 && out_alpha_reg <= 16'sd16384)
        else $error("fire alpha out of range");

    // ramp death only comes from ramp kinds
    a_ramp_kind: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_rdead_reg
        |-> (s1_kind_reg == KIND_FIRE || s1_kind_reg == KIND_EXPLODE ||
             s1_kind_reg == KIND_EXPLODE2 || s1_kind_reg == KIND_FALLSPARK))
        else $error("ramp death on a kind without ramp");

endmodule
